// ----- rtl/sfpq_pkg.sv -----
// ----------------------------------------------------------------------------
// sfpq_pkg
// Shared codes and types of the stable four-class priority queue.
// ----------------------------------------------------------------------------
package sfpq_pkg;

  localparam int KIND_W   = 2;
  localparam int CLASS_W  = 2;
  localparam int STATUS_W = 2;
  localparam int PTAG_W   = 16;
  localparam int OCC_W    = 5;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_INSERT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SERVE_ONE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SERVE_ALL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DISMISS   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SERVED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // Operations broadcast to every cell of the chain.
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [CLASS_W-1:0] cls;
  } cell_ctl_t;

endpackage

// ----- rtl/sfpq_if.sv -----
// ----------------------------------------------------------------------------
// sfpq_in_if / sfpq_out_if
// Valid/ready channels carrying requests into and results out of the queue.
// ----------------------------------------------------------------------------
interface sfpq_in_if;
  logic                            valid;
  logic                            ready;
  logic [sfpq_pkg::KIND_W-1:0]     kind;
  logic [sfpq_pkg::PTAG_W-1:0]     entry_tag;
  logic [sfpq_pkg::CLASS_W-1:0]    priority_class;

  modport source (output valid, output kind, output entry_tag, output priority_class,
                  input ready);
  modport sink   (input valid, input kind, input entry_tag, input priority_class,
                  output ready);
endinterface

interface sfpq_out_if;
  logic                            valid;
  logic                            ready;
  logic [sfpq_pkg::STATUS_W-1:0]   status;
  logic [sfpq_pkg::PTAG_W-1:0]     served_tag;
  logic [sfpq_pkg::CLASS_W-1:0]    served_class;
  logic [sfpq_pkg::OCC_W-1:0]      occupancy;
  logic                            last;

  modport source (output valid, output status, output served_tag, output served_class,
                  output occupancy, output last, input ready);
  modport sink   (input valid, input status, input served_tag, input served_class,
                  input occupancy, input last, output ready);
endinterface

// ----- rtl/sfpq_cell.sv -----
// ----------------------------------------------------------------------------
// sfpq_cell
// One slot of the sorted chain: keeps, takes the new entry, or takes a
// neighbor's entry, according to the broadcast operation.
// ----------------------------------------------------------------------------
module sfpq_cell #(
  parameter int TAG_BITS = 16
) (
  input  logic                           clk,
  input  sfpq_pkg::cell_ctl_t            ctl,
  input  logic [TAG_BITS-1:0]            ins_tag,
  input  logic                           occupied,
  input  logic                           prev_after,
  input  logic [TAG_BITS-1:0]            left_tag,
  input  logic [sfpq_pkg::CLASS_W-1:0]   left_cls,
  input  logic [TAG_BITS-1:0]            right_tag,
  input  logic [sfpq_pkg::CLASS_W-1:0]   right_cls,
  output logic [TAG_BITS-1:0]            tag,
  output logic [sfpq_pkg::CLASS_W-1:0]   cls,
  output logic                           after
);

  logic [TAG_BITS-1:0]          tag_r, tag_nxt;
  logic [sfpq_pkg::CLASS_W-1:0] cls_r, cls_nxt;

  // The new entry goes behind every held entry of equal or higher class.
  assign after = occupied && (cls_r >= ctl.cls);

  always_comb begin
    tag_nxt = tag_r;
    cls_nxt = cls_r;
    unique case (ctl.op)
      sfpq_pkg::OP_INSERT: begin
        if (!after) begin
          if (prev_after) begin
            tag_nxt = ins_tag;
            cls_nxt = ctl.cls;
          end else begin
            tag_nxt = left_tag;
            cls_nxt = left_cls;
          end
        end
      end
      sfpq_pkg::OP_POP: begin
        tag_nxt = right_tag;
        cls_nxt = right_cls;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    cls_r <= cls_nxt;
  end

  assign tag = tag_r;
  assign cls = cls_r;

endmodule

// ----- rtl/stable_four_class_priority_queue.sv -----
// ----------------------------------------------------------------------------
// stable_four_class_priority_queue
// Bounded priority queue of tagged entries in four classes, kept sorted in a
// chain of cells; entries of one class leave first in, first out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per beat: kind (insert, serve one, serve all,
//   dismiss), entry_tag and priority_class. out_ch carries result beats with
//   status, served_tag, served_class, occupancy and a last marker.
//   Every request produces its first result in the cycle after acceptance, held
//   in an output register until the receiver takes it.
//   Insert, serve one and dismiss each yield one result, so with a receiver
//   that never stalls one request is taken every cycle. Serve all on a queue
//   of N entries yields N results in one run, and the input stays not ready
//   until the final one has been loaded.
//   An insert is a single shift of the cell chain: every cell compares
//   its class with the new one at once and either keeps, takes the new entry
//   or takes its left neighbor's. A pop shifts every cell one place left.
//   When the receiver stalls, the result stays in the output register and
//   the input is held off; no beat is dropped or repeated.
//   Reset empties the queue (the fill count goes to zero); the slot contents
//   are not cleared, as only slots below the count are ever read.
// ----------------------------------------------------------------------------
module stable_four_class_priority_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  sfpq_in_if.sink      in_ch,
  sfpq_out_if.source   out_ch
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Fill count and drain flag of a running serve-all.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             drain_r, drain_nxt;

  // Output register.
  logic                             out_valid_r;
  logic [sfpq_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic [sfpq_pkg::PTAG_W-1:0]      tag_out_r, tag_out_nxt;
  logic [sfpq_pkg::CLASS_W-1:0]     cls_out_r, cls_out_nxt;
  logic [sfpq_pkg::OCC_W-1:0]       occ_out_r, occ_out_nxt;
  logic                             last_r, last_nxt;
  logic [CNT_W-1:0]                 occ_cnt;
  logic [CNT_W+sfpq_pkg::OCC_W-1:0] occ_ext;
  logic                             load;

  // Cell chain.
  sfpq_pkg::cell_ctl_t              ctl;
  logic [TAG_BITS-1:0]              cell_tag [QUEUE_DEPTH];
  logic [sfpq_pkg::CLASS_W-1:0]     cell_cls [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]           cell_after;
  logic [QUEUE_DEPTH-1:0]           cell_occ;
  logic [TAG_BITS+sfpq_pkg::PTAG_W-1:0] ins_ext;
  logic [TAG_BITS-1:0]              ins_tag;
  logic [TAG_BITS+sfpq_pkg::PTAG_W-1:0] head_ext;

  logic can_load, accept, is_full, is_empty;

  assign can_load = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !drain_r && can_load;
  assign accept = in_ch.valid && in_ch.ready;
  assign is_full = (count_r == CNT_FULL);
  assign is_empty = (count_r == '0);

  // Only the low TAG_BITS of a tag are stored; served tags are 16 bits wide.
  assign ins_ext  = {{TAG_BITS{1'b0}}, in_ch.entry_tag};
  assign ins_tag  = ins_ext[TAG_BITS-1:0];
  assign head_ext = {{sfpq_pkg::PTAG_W{1'b0}}, cell_tag[0]};

  always_comb begin
    count_nxt   = count_r;
    drain_nxt   = drain_r;
    load        = 1'b0;
    ctl.op      = sfpq_pkg::OP_HOLD;
    ctl.cls     = in_ch.priority_class;
    status_nxt  = sfpq_pkg::ST_DONE;
    tag_out_nxt = '0;
    cls_out_nxt = '0;
    occ_cnt     = count_r;
    last_nxt    = 1'b1;
    if (drain_r && can_load) begin
      // Next beat of a serve-all run.
      load        = 1'b1;
      ctl.op      = sfpq_pkg::OP_POP;
      status_nxt  = sfpq_pkg::ST_SERVED;
      tag_out_nxt = head_ext[sfpq_pkg::PTAG_W-1:0];
      cls_out_nxt = cell_cls[0];
      count_nxt   = count_r - CNT_ONE;
      occ_cnt     = count_r - CNT_ONE;
      last_nxt    = (count_r == CNT_ONE);
      drain_nxt   = (count_r != CNT_ONE);
    end else if (accept) begin
      load = 1'b1;
      unique case (in_ch.kind) inside
        sfpq_pkg::KIND_INSERT: begin
          if (is_full) begin
            status_nxt = sfpq_pkg::ST_FULL;
          end else begin
            ctl.op    = sfpq_pkg::OP_INSERT;
            count_nxt = count_r + CNT_ONE;
            occ_cnt   = count_r + CNT_ONE;
          end
        end
        sfpq_pkg::KIND_SERVE_ONE,
        sfpq_pkg::KIND_SERVE_ALL: begin
          if (is_empty) begin
            status_nxt = sfpq_pkg::ST_EMPTY;
          end else begin
            ctl.op      = sfpq_pkg::OP_POP;
            status_nxt  = sfpq_pkg::ST_SERVED;
            tag_out_nxt = head_ext[sfpq_pkg::PTAG_W-1:0];
            cls_out_nxt = cell_cls[0];
            count_nxt   = count_r - CNT_ONE;
            occ_cnt     = count_r - CNT_ONE;
            if (in_ch.kind == sfpq_pkg::KIND_SERVE_ALL) begin
              last_nxt  = (count_r == CNT_ONE);
              drain_nxt = (count_r != CNT_ONE);
            end
          end
        end
        sfpq_pkg::KIND_DISMISS: begin
          count_nxt = '0;
          occ_cnt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Occupancy is reported modulo 32.
  assign occ_ext     = {{sfpq_pkg::OCC_W{1'b0}}, occ_cnt};
  assign occ_out_nxt = occ_ext[sfpq_pkg::OCC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      drain_r <= drain_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r  <= status_nxt;
      tag_out_r <= tag_out_nxt;
      cls_out_r <= cls_out_nxt;
      occ_out_r <= occ_out_nxt;
      last_r    <= last_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.served_tag   = tag_out_r;
  assign out_ch.served_class = cls_out_r;
  assign out_ch.occupancy    = occ_out_r;
  assign out_ch.last         = last_r;

  // The chain: cell 0 is the head of the queue.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic                          prev_after;
    logic [TAG_BITS-1:0]           left_tag;
    logic [sfpq_pkg::CLASS_W-1:0]  left_cls;
    logic [TAG_BITS-1:0]           right_tag;
    logic [sfpq_pkg::CLASS_W-1:0]  right_cls;

    assign cell_occ[i] = (IDX < count_r);

    if (i == 0) begin : g_head
      assign prev_after = 1'b1;
      assign left_tag   = ins_tag;
      assign left_cls   = ctl.cls;
    end else begin : g_body
      assign prev_after = cell_after[i-1];
      assign left_tag   = cell_tag[i-1];
      assign left_cls   = cell_cls[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_tag = cell_tag[i];
      assign right_cls = cell_cls[i];
    end else begin : g_inner
      assign right_tag = cell_tag[i+1];
      assign right_cls = cell_cls[i+1];
    end

    sfpq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .ins_tag    (ins_tag),
      .occupied   (cell_occ[i]),
      .prev_after (prev_after),
      .left_tag   (left_tag),
      .left_cls   (left_cls),
      .right_tag  (right_tag),
      .right_cls  (right_cls),
      .tag        (cell_tag[i]),
      .cls        (cell_cls[i]),
      .after      (cell_after[i])
    );
  end

  // The fill count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count exceeds depth");

  // A serve-all run only continues while entries remain.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> (count_r != '0))
    else $error("drain active on empty queue");

  // A served beat that is not last must be followed by more of the run.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == sfpq_pkg::ST_SERVED) && !last_r) |-> drain_r)
    else $error("serve-all run ended without last marker");

  // Inserts never reach the chain while the queue is full.
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == sfpq_pkg::OP_INSERT) |-> !is_full)
    else $error("insert issued into full queue");

endmodule

// ----- verif/sfpq_scoreboard_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpq_scoreboard_pkg
// A mirror of the priority queue that predicts every result beat and checks
// the beats that come out of the block.
// ----------------------------------------------------------------------------
package sfpq_scoreboard_pkg;

  localparam int QDEPTH = 16;

  typedef struct packed {
    logic [sfpq_pkg::STATUS_W-1:0] status;
    logic [sfpq_pkg::PTAG_W-1:0]   tag;
    logic [sfpq_pkg::CLASS_W-1:0]  cls;
    logic [sfpq_pkg::OCC_W-1:0]    occ;
    logic                          last;
  } queue_result_t;

  class queue_scoreboard;

    // Mirror of the queue contents; slot 0 is the head.
    logic [sfpq_pkg::PTAG_W-1:0]  mirror_tag[QDEPTH];
    logic [sfpq_pkg::CLASS_W-1:0] mirror_cls[QDEPTH];
    int unsigned                  mirror_count;

    queue_result_t due_results[$];

    int unsigned errors;
    int unsigned results_checked;
    int unsigned kind_seen[4];
    int unsigned full_refusals;
    int unsigned empty_replies;
    int unsigned peak_fill;

    function new();
      mirror_count = 0;
      errors = 0;
      results_checked = 0;
      full_refusals = 0;
      empty_replies = 0;
      peak_fill = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function automatic void push_due(logic [sfpq_pkg::STATUS_W-1:0] status,
                                     logic [sfpq_pkg::PTAG_W-1:0] tag,
                                     logic [sfpq_pkg::CLASS_W-1:0] cls, logic last);
      queue_result_t r;
      r.status = status;
      r.tag    = tag;
      r.cls    = cls;
      r.occ    = mirror_count[sfpq_pkg::OCC_W-1:0];
      r.last   = last;
      due_results.push_back(r);
    endfunction

    // Removes the head and shifts the rest one place forward.
    function automatic void serve_head();
      logic [sfpq_pkg::PTAG_W-1:0]  tag;
      logic [sfpq_pkg::CLASS_W-1:0] cls;
      tag = mirror_tag[0];
      cls = mirror_cls[0];
      for (int i = 1; i < mirror_count; i++) begin
        mirror_tag[i-1] = mirror_tag[i];
        mirror_cls[i-1] = mirror_cls[i];
      end
      mirror_count--;
      push_due(sfpq_pkg::ST_SERVED, tag, cls, mirror_count == 0);
    endfunction

    // Called once per accepted request beat.
    function automatic void note_request(logic [sfpq_pkg::KIND_W-1:0] kind,
                                         logic [sfpq_pkg::PTAG_W-1:0] tag,
                                         logic [sfpq_pkg::CLASS_W-1:0] cls);
      int unsigned pos;
      kind_seen[kind]++;
      case (kind) inside
        sfpq_pkg::KIND_INSERT: begin
          if (mirror_count >= QDEPTH) begin
            full_refusals++;
            push_due(sfpq_pkg::ST_FULL, '0, '0, 1'b1);
          end else begin
            // Stable placement: behind every entry of equal or higher class.
            pos = 0;
            while (pos < mirror_count && mirror_cls[pos] >= cls) pos++;
            for (int i = mirror_count; i > pos; i--) begin
              mirror_tag[i] = mirror_tag[i-1];
              mirror_cls[i] = mirror_cls[i-1];
            end
            mirror_tag[pos] = tag;
            mirror_cls[pos] = cls;
            mirror_count++;
            if (mirror_count > peak_fill) peak_fill = mirror_count;
            push_due(sfpq_pkg::ST_DONE, '0, '0, 1'b1);
          end
        end
        sfpq_pkg::KIND_SERVE_ONE, sfpq_pkg::KIND_SERVE_ALL: begin
          if (mirror_count == 0) begin
            empty_replies++;
            push_due(sfpq_pkg::ST_EMPTY, '0, '0, 1'b1);
          end else if (kind == sfpq_pkg::KIND_SERVE_ONE) begin
            serve_head();
            // Only one beat for serve one, so it always carries last.
            due_results[$].last = 1'b1;
          end else begin
            while (mirror_count > 0) serve_head();
          end
        end
        default: begin
          mirror_count = 0;
          push_due(sfpq_pkg::ST_DONE, '0, '0, 1'b1);
        end
      endcase
    endfunction

    function automatic void report(string what, queue_result_t got, queue_result_t want);
      errors++;
      if (errors <= 10) begin
        $display("[%0t] %s", $time, what);
        $display("  expected st=%0d tag=%h cls=%0d occ=%0d last=%0b",
                 want.status, want.tag, want.cls, want.occ, want.last);
        $display("  got      st=%0d tag=%h cls=%0d occ=%0d last=%0b",
                 got.status, got.tag, got.cls, got.occ, got.last);
      end
    endfunction

    // Called once per accepted result beat.
    function automatic void check_result(queue_result_t got);
      queue_result_t want;
      string         bad;
      if (due_results.size() == 0) begin
        report("result beat with nothing outstanding", got, '0);
        return;
      end
      want = due_results.pop_front();
      results_checked++;
      bad = "";
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.tag    !== want.tag)    bad = {bad, " served_tag"};
      if (got.cls    !== want.cls)    bad = {bad, " served_class"};
      if (got.occ    !== want.occ)    bad = {bad, " occupancy"};
      if (got.last   !== want.last)   bad = {bad, " last"};
      if (bad != "") report({"mismatch in", bad}, got, want);
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void close_out();
      if (due_results.size() != 0) begin
        errors += due_results.size();
        $display("%0d result beats never arrived", due_results.size());
      end
    endfunction

  endclass

endpackage

// ----- verif/tb_stable_four_class_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_four_class_priority_queue
// Self-checking bench for the stable four-class priority queue. Requests go
// in through a valid/ready channel with random gaps; every result beat is
// compared field by field against a mirror of the queue kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb_stable_four_class_priority_queue;

  localparam int TB_KIND_W  = sfpq_pkg::KIND_W;
  localparam int TB_TAG_W   = sfpq_pkg::PTAG_W;
  localparam int TB_CLASS_W = sfpq_pkg::CLASS_W;
  localparam int TB_QDEPTH  = sfpq_scoreboard_pkg::QDEPTH;

  // Length of the deliberate receiver hold-off, in cycles. It is far longer
  // than the block can buffer, so the input side must stall.
  localparam int HOLD_CYCLES = 90;

  logic clk;
  logic rst_n;

  sfpq_in_if  in_ch();
  sfpq_out_if out_ch();

  stable_four_class_priority_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sfpq_scoreboard_pkg::queue_scoreboard ledger;

  // When clear, neither side inserts random idle cycles.
  bit          idle_enabled = 1'b1;
  // Raised once by the stimulus to ask the receiver for its long hold-off.
  bit          hold_pending = 1'b0;
  // Cycles during the hold-off at which the block refused an offered beat.
  int unsigned refused_during_hold = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Safety net: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout waiting for the queue to finish");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Tags at the extremes turn up more often than uniform sampling would give.
  function automatic logic [TB_TAG_W-1:0] pick_tag();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    return TB_TAG_W'($urandom());
  endfunction

  // Offers one request beat and returns at the edge where it is accepted.
  // valid is left high on return, so back-to-back requests never lower and
  // raise it within the same time step.
  task automatic offer_request(input logic [TB_KIND_W-1:0] kind,
                               input logic [TB_TAG_W-1:0] tag,
                               input logic [TB_CLASS_W-1:0] cls);
    while (idle_enabled && $urandom_range(99, 0) < 26) begin
      // Junk on the payload while valid is low must be ignored.
      in_ch.valid          <= 1'b0;
      in_ch.kind           <= TB_KIND_W'($urandom());
      in_ch.entry_tag      <= TB_TAG_W'($urandom());
      in_ch.priority_class <= TB_CLASS_W'($urandom());
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.kind           <= kind;
    in_ch.entry_tag      <= tag;
    in_ch.priority_class <= cls;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ledger.note_request(kind, tag, cls);
  endtask

  // Receiver: checks each accepted result beat, then decides ready for the
  // next edge. The long hold-off is counted here so that it runs on its own
  // while the sender keeps offering requests.
  initial begin
    int unsigned                        hold_left;
    sfpq_scoreboard_pkg::queue_result_t beat;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        beat.status = out_ch.status;
        beat.tag    = out_ch.served_tag;
        beat.cls    = out_ch.served_class;
        beat.occ    = out_ch.occupancy;
        beat.last   = out_ch.last;
        ledger.check_result(beat);
      end
      if (hold_left > 0) begin
        if (in_ch.valid && !in_ch.ready) refused_during_hold++;
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !idle_enabled || ($urandom_range(99, 0) >= 26);
      end
    end
  end

  // Stimulus: a directed opening, then random rounds, then the drain.
  initial begin
    logic [TB_KIND_W-1:0] kind;
    int unsigned          roll;
    bit                   fill_heavy;

    ledger = new();
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.kind           <= sfpq_pkg::KIND_INSERT;
    in_ch.entry_tag      <= '0;
    in_ch.priority_class <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every request kind against an empty queue: both serves report empty,
    // and dismiss still answers done.
    offer_request(sfpq_pkg::KIND_SERVE_ONE, '1, 2'd3);
    offer_request(sfpq_pkg::KIND_SERVE_ALL, '1, 2'd3);
    offer_request(sfpq_pkg::KIND_DISMISS,   '1, 2'd3);

    // Sixteen inserts fill the queue. The class pattern repeats, so equal
    // classes arrive at different times and their order shows whether the
    // queue keeps them first in, first out. Tags run from all zeros to all
    // ones.
    for (int i = 0; i < TB_QDEPTH; i++)
      offer_request(sfpq_pkg::KIND_INSERT,
                    (i == 0) ? 16'h0000 :
                    (i == TB_QDEPTH - 1) ? 16'hFFFF : TB_TAG_W'(16'h1111 * i),
                    TB_CLASS_W'((i * 3 + 1) % 4));
    // One more insert is refused because the queue is full.
    offer_request(sfpq_pkg::KIND_INSERT, 16'hA5A5, 2'd3);
    offer_request(sfpq_pkg::KIND_SERVE_ONE, '0, 2'd0);
    // Dismiss on a queue that still holds entries.
    offer_request(sfpq_pkg::KIND_DISMISS, '0, 2'd0);
    // A small mixed set and then one serve all that drains it in a run.
    offer_request(sfpq_pkg::KIND_INSERT, 16'h0F0F, 2'd0);
    offer_request(sfpq_pkg::KIND_INSERT, 16'hF0F0, 2'd2);
    offer_request(sfpq_pkg::KIND_INSERT, 16'h5A5A, 2'd2);
    offer_request(sfpq_pkg::KIND_SERVE_ALL, '0, 2'd0);

    // Random rounds of twenty requests. Most rounds lean on inserts so the
    // queue fills and long serve-all runs happen; the others churn. Two
    // rounds run with no idling, and one starts the long receiver hold.
    for (int round = 0; round < 8; round++) begin
      idle_enabled = !(round == 3 || round == 4);
      if (round == 6) hold_pending = 1'b1;
      fill_heavy = (round % 3 != 2);
      for (int k = 0; k < 20; k++) begin
        roll = $urandom_range(99, 0);
        if (fill_heavy)
          kind = (roll < 80) ? sfpq_pkg::KIND_INSERT :
                 (roll < 91) ? sfpq_pkg::KIND_SERVE_ONE :
                 (roll < 97) ? sfpq_pkg::KIND_SERVE_ALL : sfpq_pkg::KIND_DISMISS;
        else
          kind = (roll < 45) ? sfpq_pkg::KIND_INSERT :
                 (roll < 75) ? sfpq_pkg::KIND_SERVE_ONE :
                 (roll < 90) ? sfpq_pkg::KIND_SERVE_ALL : sfpq_pkg::KIND_DISMISS;
        offer_request(kind, pick_tag(), TB_CLASS_W'($urandom_range(3, 0)));
      end
    end
    idle_enabled = 1'b1;
    in_ch.valid <= 1'b0;

    // Wait for every outstanding beat, then a little longer so that any
    // extra beat from the block is caught as unexpected.
    while (ledger.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    ledger.close_out();

    $display("Requests: %0d insert, %0d serve one, %0d serve all, %0d dismiss",
             ledger.kind_seen[sfpq_pkg::KIND_INSERT],
             ledger.kind_seen[sfpq_pkg::KIND_SERVE_ONE],
             ledger.kind_seen[sfpq_pkg::KIND_SERVE_ALL],
             ledger.kind_seen[sfpq_pkg::KIND_DISMISS]);
    $display("%0d result beats checked, %0d full refusals, %0d empty replies",
             ledger.results_checked, ledger.full_refusals, ledger.empty_replies);
    $display("Peak fill %0d, input stalled %0d cycles in hold",
             ledger.peak_fill, refused_during_hold);
    if (ledger.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sfpq_pkg.sv
rtl/sfpq_if.sv
rtl/sfpq_cell.sv
rtl/stable_four_class_priority_queue.sv
verif/sfpq_scoreboard_pkg.sv
verif/tb_stable_four_class_priority_queue.sv
